### rtl/core/tts_pkg.sv
// shared types, constants and codes for the task table scheduler
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
    localparam int TASK_SLOTS = 32;
    localparam int LOCK_COUNT = 8;
    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int LOCK_W = $clog2(LOCK_COUNT);
    localparam int SCNT_W = $clog2(TASK_SLOTS + 1);

    localparam logic [2:0] K_CREATE  = 3'd0;
    localparam logic [2:0] K_EXIT    = 3'd1;
    localparam logic [2:0] K_YIELD   = 3'd2;
    localparam logic [2:0] K_DELAY   = 3'd3;
    localparam logic [2:0] K_SCHED   = 3'd4;
    localparam logic [2:0] K_ACQUIRE = 3'd5;
    localparam logic [2:0] K_RELEASE = 3'd6;

    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_SLEEPING = 3'd1;
    localparam logic [2:0] ST_BLOCKED  = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_READY    = 3'd4;

    localparam logic [3:0] RC_DONE       = 4'd0;
    localparam logic [3:0] RC_NOSLOT     = 4'd1;
    localparam logic [3:0] RC_NOCUR      = 4'd2;
    localparam logic [3:0] RC_RUNNING    = 4'd3;
    localparam logic [3:0] RC_GRANTED    = 4'd4;
    localparam logic [3:0] RC_BLOCKED    = 4'd5;
    localparam logic [3:0] RC_DISPATCHED = 4'd6;
    localparam logic [3:0] RC_SLEEP      = 4'd7;
    localparam logic [3:0] RC_NOTHING    = 4'd8;

    localparam logic [1:0] CFG_TPM    = 2'd0;
    localparam logic [1:0] CFG_SLICE  = 2'd1;
    localparam logic [1:0] CFG_MARGIN = 2'd2;
    localparam logic [1:0] CFG_LEAD   = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] now;
        logic [31:0] delay_ms;
        logic [2:0]  lock_id;
    } t_item;

    typedef struct packed {
        logic [3:0]  result_code;
        logic [4:0]  task_id;
        logic [63:0] alarm_time;
    } t_result;
endpackage
`default_nettype wire

### rtl/core/tts_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps
`default_nettype none
interface tts_item_if;
    logic valid;
    logic ready;
    logic [2:0]  kind;
    logic [63:0] now;
    logic [31:0] delay_ms;
    logic [2:0]  lock_id;
    modport source (output valid, kind, now, delay_ms, lock_id, input ready);
    modport sink (input valid, kind, now, delay_ms, lock_id, output ready);
endinterface

interface tts_result_if;
    logic valid;
    logic ready;
    logic [3:0]  result_code;
    logic [4:0]  task_id;
    logic [63:0] alarm_time;
    modport source (output valid, result_code, task_id, alarm_time, input ready);
    modport sink (input valid, result_code, task_id, alarm_time, output ready);
endinterface
`default_nettype wire

### rtl/core/tts_front.sv
// input stage and two-entry item queue
`timescale 1ns / 1ps
`default_nettype none
module tts_front (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  wire  tts_pkg::t_item i_item,
    output logic o_valid,
    input  wire  i_ready,
    output tts_pkg::t_item o_item
);
    tts_pkg::t_item r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### rtl/core/tts_back.sv
// task table, lock state and the sequencer that executes items
`timescale 1ns / 1ps
`default_nettype none
module tts_back (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  wire  tts_pkg::t_item i_item,
    output logic o_valid,
    input  wire  i_ready,
    output tts_pkg::t_result o_res,
    input  wire  i_cfg_we,
    input  wire  [1:0] i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);
    localparam int NS = tts_pkg::TASK_SLOTS;
    localparam int SW = tts_pkg::SLOT_W;
    localparam int CW = tts_pkg::SCNT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DISP = 8'b0000_0010,
        S_SCAN = 8'b0000_0100,
        S_RDWT = 8'b0000_1000,
        S_PICK = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_st;
    logic [19:0] r_tpm;
    logic [15:0] r_slice;
    logic [31:0] r_margin, r_lead;

    logic [2:0]  r_status [NS];
    logic [63:0] r_wake [NS];   // memory, undefined until written; the value read is used only for sleeping slots
    logic [63:0] r_last [NS];   // memory with valid bits
    logic [NS-1:0] r_last_v;
    logic [SW-1:0] r_run;
    logic r_run_v;
    logic [tts_pkg::LOCK_COUNT-1:0] r_held;
    logic [NS-1:0] r_wait [tts_pkg::LOCK_COUNT];

    tts_pkg::t_item r_it;
    tts_pkg::t_result r_res;
    tts_pkg::t_result n_res;
    logic r_res_v;

    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_ridx;
    logic [2:0] r_rstat;
    logic [63:0] r_rwake, r_rlast;
    logic r_have_w, r_have_p;
    logic [63:0] r_minw, r_minl;
    logic [SW-1:0] r_pick;
    logic [63:0] r_prod;

    logic [SW-1:0] freeslot;
    logic freefound;
    logic [63:0] rlast_eff;
    logic [63:0] mw_diff;

    assign o_valid = r_res_v;
    assign o_res = r_res;
    assign o_ready = (r_st == S_IDLE) && !r_res_v;
    assign rlast_eff = r_last_v[r_ridx] ? r_rlast : 64'd0;
    assign mw_diff = r_minw - r_it.now;

    always_comb begin
        freeslot = '0;
        freefound = 1'b0;
        for (int k = NS - 1; k >= 0; k--) begin
            if (r_status[k] == tts_pkg::ST_FREE) begin
                freeslot = SW'(k);
                freefound = 1'b1;
            end
        end
    end

    // result of a non-scan item
    always_comb begin
        n_res = '{result_code: tts_pkg::RC_DONE, task_id: '0, alarm_time: '0};
        case (r_it.kind)
            tts_pkg::K_CREATE: begin
                if (freefound) begin
                    n_res.task_id = 5'(freeslot);
                end else begin
                    n_res.result_code = tts_pkg::RC_NOSLOT;
                end
            end
            tts_pkg::K_EXIT, tts_pkg::K_YIELD, tts_pkg::K_DELAY,
            tts_pkg::K_ACQUIRE: begin
                if (!r_run_v) begin
                    n_res.result_code = tts_pkg::RC_NOCUR;
                end else begin
                    n_res.task_id = 5'(r_run);
                    if (r_it.kind == tts_pkg::K_ACQUIRE) begin
                        n_res.result_code = r_held[r_it.lock_id] ? tts_pkg::RC_BLOCKED
                                                                 : tts_pkg::RC_GRANTED;
                    end
                end
            end
            tts_pkg::K_SCHED: begin
                if (r_run_v) begin
                    n_res.result_code = tts_pkg::RC_RUNNING;
                    n_res.task_id = 5'(r_run);
                end
            end
            default: ;
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        r_rwake <= r_wake[r_idx[SW-1:0]];
        r_rlast <= r_last[r_idx[SW-1:0]];
        if (r_st == S_DISP && r_it.kind == tts_pkg::K_DELAY && r_run_v) begin
            r_wake[r_run] <= r_it.now + r_prod;
        end
        if (r_st == S_DISP && r_run_v && (r_it.kind == tts_pkg::K_EXIT
                || r_it.kind == tts_pkg::K_YIELD || r_it.kind == tts_pkg::K_DELAY
                || (r_it.kind == tts_pkg::K_ACQUIRE && r_held[r_it.lock_id]))) begin
            r_last[r_run] <= r_it.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_tpm <= 20'd1000;
            r_slice <= 16'd25;
            r_margin <= 32'd1000;
            r_lead <= 32'd500;
            for (int k = 0; k < NS; k++) r_status[k] <= tts_pkg::ST_FREE;
            r_last_v <= '0;
            r_run <= '0;
            r_run_v <= 1'b0;
            r_held <= '0;
            for (int k = 0; k < tts_pkg::LOCK_COUNT; k++) r_wait[k] <= '0;
            r_res_v <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tts_pkg::CFG_TPM:    r_tpm <= i_cfg_data[19:0];
                    tts_pkg::CFG_SLICE:  r_slice <= i_cfg_data[15:0];
                    tts_pkg::CFG_MARGIN: r_margin <= i_cfg_data;
                    tts_pkg::CFG_LEAD:   r_lead <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_res_v && i_ready) r_res_v <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_it <= i_item;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    // delay product or slice product, one 32x20 multiply
                    if (r_it.kind == tts_pkg::K_DELAY) begin
                        r_prod <= 64'(r_it.delay_ms) * 64'(r_tpm);
                    end else begin
                        r_prod <= 64'(r_slice) * 64'(r_tpm);
                    end
                    r_st <= S_DISP;
                end
                S_DISP: begin
                    r_res <= n_res;
                    r_st <= (r_it.kind == tts_pkg::K_SCHED && !r_run_v) ? S_RDWT : S_OUT;
                    case (r_it.kind)
                        tts_pkg::K_CREATE: begin
                            if (freefound) begin
                                r_status[freeslot] <= tts_pkg::ST_READY;
                            end
                        end
                        tts_pkg::K_EXIT, tts_pkg::K_YIELD, tts_pkg::K_DELAY,
                        tts_pkg::K_ACQUIRE: begin
                            if (r_run_v) begin
                                case (r_it.kind)
                                    tts_pkg::K_EXIT: r_status[r_run] <= tts_pkg::ST_FREE;
                                    tts_pkg::K_YIELD: r_status[r_run] <= tts_pkg::ST_READY;
                                    tts_pkg::K_DELAY:
                                        r_status[r_run] <= tts_pkg::ST_SLEEPING;
                                    default: begin
                                        if (r_held[r_it.lock_id]) begin
                                            r_status[r_run] <= tts_pkg::ST_BLOCKED;
                                            r_wait[r_it.lock_id][r_run] <= 1'b1;
                                        end else begin
                                            r_held[r_it.lock_id] <= 1'b1;
                                        end
                                    end
                                endcase
                                if (r_it.kind != tts_pkg::K_ACQUIRE
                                        || r_held[r_it.lock_id]) begin
                                    r_run_v <= 1'b0;
                                    r_last_v[r_run] <= 1'b1;
                                end
                            end
                        end
                        tts_pkg::K_SCHED: begin
                            if (!r_run_v) begin
                                r_idx <= '0;
                                r_have_w <= 1'b0;
                                r_have_p <= 1'b0;
                                r_minw <= '0;
                                r_minl <= '0;
                                r_pick <= '0;
                            end
                        end
                        tts_pkg::K_RELEASE: begin
                            r_held[r_it.lock_id] <= 1'b0;
                            for (int k = 0; k < NS; k++) begin
                                if (r_wait[r_it.lock_id][k]
                                        && r_status[k] == tts_pkg::ST_BLOCKED)
                                    r_status[k] <= tts_pkg::ST_READY;
                            end
                            r_wait[r_it.lock_id] <= '0;
                        end
                        default: ;
                    endcase
                end
                S_RDWT: begin
                    // memory read of slot r_idx lands next cycle
                    r_ridx <= r_idx[SW-1:0];
                    r_rstat <= r_status[r_idx[SW-1:0]];
                    r_idx <= r_idx + 1'b1;
                    r_st <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_rstat == tts_pkg::ST_SLEEPING && r_rwake <= r_it.now) begin
                        r_status[r_ridx] <= tts_pkg::ST_READY;
                    end
                    if (r_rstat == tts_pkg::ST_SLEEPING && r_rwake > r_it.now
                            && (!r_have_w || r_rwake < r_minw)) begin
                        r_minw <= r_rwake;
                        r_have_w <= 1'b1;
                    end
                    if ((r_rstat == tts_pkg::ST_READY || (r_rstat == tts_pkg::ST_SLEEPING
                            && r_rwake <= r_it.now))
                            && (!r_have_p || rlast_eff < r_minl)) begin
                        r_minl <= rlast_eff;
                        r_pick <= r_ridx;
                        r_have_p <= 1'b1;
                    end
                    r_st <= (r_idx == CW'(NS)) ? S_PICK : S_RDWT;
                end
                S_PICK: begin
                    r_st <= S_OUT;
                    if (r_have_p) begin
                        r_status[r_pick] <= tts_pkg::ST_RUNNING;
                        r_run <= r_pick;
                        r_run_v <= 1'b1;
                        r_res <= '{result_code: tts_pkg::RC_DISPATCHED,
                                   task_id: 5'(r_pick), alarm_time: r_it.now + r_prod};
                    end else if (r_have_w && mw_diff > 64'(r_margin)) begin
                        r_res <= '{result_code: tts_pkg::RC_SLEEP, task_id: '0,
                                   alarm_time: (r_minw >= 64'(r_lead))
                                       ? r_minw - 64'(r_lead) : 64'd0};
                    end else begin
                        r_res <= '{result_code: tts_pkg::RC_NOTHING, task_id: '0,
                                   alarm_time: '0};
                    end
                end
                S_FIN: r_st <= S_IDLE;
                S_OUT: begin
                    r_res_v <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/task_table_scheduler.sv
// top level of the task table scheduler
// Items are executed one at a time through the multiply, dispatch and
// output states; a schedule with no task running also walks all 32 task
// slots through the wake and last-run memories, a read and a scan state
// per slot. A two-beat queue in front lets the producer hand over items
// while the executor is busy; the result register holds one beat.
`timescale 1ns / 1ps
`default_nettype none
module task_table_scheduler (
    input  wire i_clk,
    input  wire i_rst_n,
    tts_item_if.sink   item,
    tts_result_if.source result,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data
);
    tts_pkg::t_item in_it, q_it;
    tts_pkg::t_result res;
    logic q_valid, q_ready;

    assign in_it = '{kind: item.kind, now: item.now, delay_ms: item.delay_ms,
                     lock_id: item.lock_id};

    // front: input beat capture and queue
    tts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(item.valid), .o_ready(item.ready), .i_item(in_it),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_it)
    );

    // back: table state and execution
    tts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_it),
        .o_valid(result.valid), .i_ready(result.ready), .o_res(res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    assign result.result_code = res.result_code;
    assign result.task_id = res.task_id;
    assign result.alarm_time = res.alarm_time;
endmodule
`default_nettype wire

### rtl/core/tts_checker.sv
// port level checks for the task table scheduler
`timescale 1ns / 1ps
`default_nettype none
module tts_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire rv,
    input wire rr,
    input wire [3:0] rc,
    input wire [4:0] tid,
    input wire [63:0] at
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv && !rr |=> rv && $stable(rc)) else $error("result dropped");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv |-> rc <= tts_pkg::RC_NOTHING) else $error("bad code");
    a_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv && rc != tts_pkg::RC_DISPATCHED && rc != tts_pkg::RC_SLEEP |-> at == 64'd0)
        else $error("stray alarm");
    a_tid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv && (rc == tts_pkg::RC_NOSLOT || rc == tts_pkg::RC_SLEEP) |-> tid == 5'd0)
        else $error("stray id");
endmodule

bind task_table_scheduler tts_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .rv(result.valid), .rr(result.ready),
    .rc(result.result_code), .tid(result.task_id), .at(result.alarm_time)
);
`default_nettype wire
